/* rtl/sfr_pkg.sv */
// Shared types and constants for the serial frame receiver.
// No dependencies; every other file in rtl/ refers to this package by scoped names.
`default_nettype none

package sfr_pkg;

    // Frame bytes outside the payload: two header, type, length, two checksum, two tail.
    localparam int unsigned FRAME_OVERHEAD = 8;
    localparam logic [7:0]  ACK_FRAME_TYPE = 8'hFF;

    // Length field of a frame descriptor covers the largest payload in the parameter range.
    localparam int unsigned DESC_LEN_W  = 7;
    // Store index on the write port covers the largest payload in the parameter range.
    localparam int unsigned STORE_IDX_W = 6;
    localparam int unsigned CFG_IDX_W   = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_FIRST    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TAIL_SECOND   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_ENABLE    = 3'd4;

    typedef enum logic [3:0] {
        PH_HEAD1,
        PH_HEAD2,
        PH_TYPE,
        PH_LEN,
        PH_PAYLOAD,
        PH_SUM_HI,
        PH_SUM_LO,
        PH_TAIL1,
        PH_TAIL2
    } front_phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_FETCH,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic       action;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [7:0] frame_type;
        logic [5:0] payload_length;
        logic [7:0] payload_byte;
        logic [5:0] byte_index;
        logic       last;
        logic       send_ack;
        logic       awaiting_ack;
    } out_item_t;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] tail_first;
        logic [7:0] tail_second;
        logic       ack_enable;
    } cfg_t;

    // One completed frame waiting for replay.
    typedef struct packed {
        logic [7:0]            frame_type;
        logic [DESC_LEN_W-1:0] len;
        logic                  send_ack;
        logic                  awaiting_ack;
        logic                  bank;
    } frame_desc_t;

    // Payload store write port, driven by the parser.
    typedef struct packed {
        logic                   en;
        logic                   bank;
        logic [STORE_IDX_W-1:0] idx;
        logic [7:0]             data;
    } store_wr_t;

endpackage

`default_nettype wire

/* rtl/sfr_front.sv */
// Frame parser: takes input beats, tracks header/length/payload/checksum/tail and ACK wait.
// Depends on sfr_pkg; writes payload bytes into the store and pushes frame descriptors.
`default_nettype none

module sfr_front #(
    parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire sfr_pkg::cfg_t       cfg,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire sfr_pkg::in_item_t   s_data,
    input  wire logic                q_full,
    output logic                     q_push,
    output sfr_pkg::frame_desc_t     q_desc,
    output sfr_pkg::store_wr_t       store_wr
);

    localparam int unsigned MAX_PAYLOAD = FRAME_BUFFER_BYTES - sfr_pkg::FRAME_OVERHEAD;
    localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);

    sfr_pkg::front_phase_t phase_reg, phase_next;
    logic [7:0]            held_type_reg, held_type_next;
    logic [LEN_W-1:0]      held_length_reg, held_length_next;
    logic [LEN_W-1:0]      fill_count_reg, fill_count_next;
    logic [15:0]           running_sum_reg, running_sum_next;
    logic [15:0]           received_sum_reg, received_sum_next;
    logic                  ack_wait_reg, ack_wait_next;
    logic                  wr_bank_reg, wr_bank_next;
    logic                  accept;
    logic [7:0]            b;

    // Hold off input while both store banks are owned by pending frames.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign b       = s_data.rx_byte;

    always_comb begin
        phase_next        = phase_reg;
        held_type_next    = held_type_reg;
        held_length_next  = held_length_reg;
        fill_count_next   = fill_count_reg;
        running_sum_next  = running_sum_reg;
        received_sum_next = received_sum_reg;
        ack_wait_next     = ack_wait_reg;
        wr_bank_next      = wr_bank_reg;
        q_push            = 1'b0;
        store_wr.en       = 1'b0;
        store_wr.bank     = wr_bank_reg;
        store_wr.idx      = sfr_pkg::STORE_IDX_W'(fill_count_reg);
        store_wr.data     = b;

        if (accept) begin
            if (s_data.action) begin
                ack_wait_next = 1'b1;
            end else begin
                case (phase_reg)
                    sfr_pkg::PH_HEAD1: begin
                        if (b == cfg.header_first) phase_next = sfr_pkg::PH_HEAD2;
                    end
                    sfr_pkg::PH_HEAD2: begin
                        if (b == cfg.header_second) phase_next = sfr_pkg::PH_TYPE;
                        else                        phase_next = sfr_pkg::PH_HEAD1;
                    end
                    sfr_pkg::PH_TYPE: begin
                        held_type_next   = b;
                        running_sum_next = {8'h00, b};
                        phase_next       = sfr_pkg::PH_LEN;
                    end
                    sfr_pkg::PH_LEN: begin
                        if (b > 8'(MAX_PAYLOAD)) begin
                            phase_next = sfr_pkg::PH_HEAD1;
                        end else begin
                            held_length_next = LEN_W'(b);
                            fill_count_next  = '0;
                            running_sum_next = running_sum_reg + {8'h00, b};
                            phase_next       = (b == 8'h00) ? sfr_pkg::PH_SUM_HI
                                                            : sfr_pkg::PH_PAYLOAD;
                        end
                    end
                    sfr_pkg::PH_PAYLOAD: begin
                        store_wr.en      = 1'b1;
                        fill_count_next  = fill_count_reg + LEN_W'(1);
                        running_sum_next = running_sum_reg + {8'h00, b};
                        if (fill_count_reg + LEN_W'(1) >= held_length_reg)
                            phase_next = sfr_pkg::PH_SUM_HI;
                    end
                    sfr_pkg::PH_SUM_HI: begin
                        received_sum_next = {b, 8'h00};
                        phase_next        = sfr_pkg::PH_SUM_LO;
                    end
                    sfr_pkg::PH_SUM_LO: begin
                        received_sum_next = {received_sum_reg[15:8], b};
                        phase_next        = sfr_pkg::PH_TAIL1;
                    end
                    sfr_pkg::PH_TAIL1: begin
                        if (b == cfg.tail_first) phase_next = sfr_pkg::PH_TAIL2;
                        else                     phase_next = sfr_pkg::PH_HEAD1;
                    end
                    sfr_pkg::PH_TAIL2: begin
                        if (b == cfg.tail_second && received_sum_reg == running_sum_reg) begin
                            if (held_type_reg == sfr_pkg::ACK_FRAME_TYPE && ack_wait_reg) begin
                                ack_wait_next = 1'b0;
                            end else begin
                                q_push       = 1'b1;
                                wr_bank_next = !wr_bank_reg;
                            end
                        end
                        phase_next = sfr_pkg::PH_HEAD1;
                    end
                    default: begin
                        phase_next = sfr_pkg::PH_HEAD1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        q_desc.frame_type   = held_type_reg;
        q_desc.len          = sfr_pkg::DESC_LEN_W'(held_length_reg);
        q_desc.send_ack     = cfg.ack_enable;
        q_desc.awaiting_ack = ack_wait_reg;
        q_desc.bank         = wr_bank_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= sfr_pkg::PH_HEAD1;
            ack_wait_reg <= 1'b0;
            wr_bank_reg  <= 1'b0;
        end else begin
            phase_reg    <= phase_next;
            ack_wait_reg <= ack_wait_next;
            wr_bank_reg  <= wr_bank_next;
        end
    end

    always_ff @(posedge aclk) begin
        held_type_reg    <= held_type_next;
        held_length_reg  <= held_length_next;
        fill_count_reg   <= fill_count_next;
        running_sum_reg  <= running_sum_next;
        received_sum_reg <= received_sum_next;
    end

endmodule

`default_nettype wire

/* rtl/sfr_queue.sv */
// Two-entry descriptor queue between the parser and the replay engine.
// Depends on sfr_pkg for the descriptor type.
`default_nettype none

module sfr_queue (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 push,
    input  wire sfr_pkg::frame_desc_t push_desc,
    input  wire logic                 pop,
    output logic                      full,
    output logic                      head_valid,
    output sfr_pkg::frame_desc_t      head
);

    sfr_pkg::frame_desc_t entry_reg [2];
    logic                 wr_ptr_reg, wr_ptr_next;
    logic                 rd_ptr_reg, rd_ptr_next;
    logic [1:0]           count_reg, count_next;

    assign full       = (count_reg == 2'd2);
    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

`default_nettype wire

/* rtl/sfr_back.sv */
// Replay engine: owns the two-bank payload store and emits one result beat per payload byte.
// Depends on sfr_pkg; reads frame descriptors from the queue head.
`default_nettype none

module sfr_back #(
    parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire sfr_pkg::store_wr_t   store_wr,
    input  wire logic                 head_valid,
    input  wire sfr_pkg::frame_desc_t head,
    output logic                      pop,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output sfr_pkg::out_item_t        m_data
);

    localparam int unsigned MAX_PAYLOAD = FRAME_BUFFER_BYTES - sfr_pkg::FRAME_OVERHEAD;
    localparam int unsigned LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int unsigned IDX_W       = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int unsigned MEM_DEPTH   = 2 << IDX_W;

    logic [7:0]             mem [MEM_DEPTH];
    logic [7:0]             rd_data_reg;
    logic [IDX_W:0]         rd_addr;
    logic [IDX_W:0]         wr_addr;

    sfr_pkg::back_state_t   state_reg, state_next;
    logic [LEN_W-1:0]       idx_reg, idx_next;
    logic                   out_valid_reg, out_valid_next;
    sfr_pkg::out_item_t     out_data_reg, out_data_next;
    logic [LEN_W-1:0]       len;
    logic                   last;
    logic                   slot_free;

    assign len       = LEN_W'(head.len);
    assign last      = (len == '0) || (idx_reg + LEN_W'(1) == len);
    assign slot_free = !out_valid_reg || m_ready;
    assign rd_addr   = {head.bank, idx_reg[IDX_W-1:0]};
    assign wr_addr   = {store_wr.bank, store_wr.idx[IDX_W-1:0]};

    // The parser only writes the bank not owned by a queued frame.
    always_ff @(posedge aclk) begin
        if (store_wr.en) mem[wr_addr] <= store_wr.data;
        rd_data_reg <= mem[rd_addr];
    end

    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        pop            = 1'b0;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;

        case (state_reg)
            sfr_pkg::BK_IDLE: begin
                idx_next = '0;
                if (head_valid) state_next = sfr_pkg::BK_FETCH;
            end
            sfr_pkg::BK_FETCH: begin
                state_next = sfr_pkg::BK_EMIT;
            end
            sfr_pkg::BK_EMIT: begin
                if (slot_free) begin
                    out_valid_next               = 1'b1;
                    out_data_next.frame_type     = head.frame_type;
                    out_data_next.payload_length = 6'(head.len);
                    out_data_next.payload_byte   = (len == '0) ? 8'h00 : rd_data_reg;
                    out_data_next.byte_index     = 6'(idx_reg);
                    out_data_next.last           = last;
                    out_data_next.send_ack       = head.send_ack;
                    out_data_next.awaiting_ack   = head.awaiting_ack;
                    if (last) begin
                        pop        = 1'b1;
                        state_next = sfr_pkg::BK_IDLE;
                    end else begin
                        idx_next   = idx_reg + LEN_W'(1);
                        state_next = sfr_pkg::BK_FETCH;
                    end
                end
            end
            default: begin
                state_next = sfr_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sfr_pkg::BK_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg      <= idx_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

/* rtl/serial_frame_receiver_with_ack.sv */
// Top level of the serial frame receiver with ACK tracking.
// Depends on sfr_pkg, sfr_front, sfr_queue and sfr_back.
// Channels:
//   s_valid/s_ready/s_data carry input beats: action 0 is a received byte, action 1
//   records that a data frame went out and sets the ACK wait flag.
//   m_valid/m_ready/m_data carry result beats: one per payload byte of each good
//   frame, or a single beat for an empty frame, with last on the final beat.
//   cfg_valid/cfg_ready/cfg_index/cfg_wdata write the header, tail and ACK enable
//   registers; cfg_ready is always high. Write them only while the block is idle.
// Timing:
//   The parser takes one input beat per cycle while s_ready is high. Replay takes each
//   result beat through a fetch state (store read) and then an emit state (output
//   load), so it does not start the next payload byte until the current beat is loaded.
//   Two store banks let one frame replay while the next is parsed; s_ready drops
//   only while both banks hold frames still waiting to drain.
// Reset:
//   aresetn (synchronous, active low) returns the parser to header hunting, clears
//   the ACK wait flag and the configuration registers, empties the queue and drops any result beat.
// Stalls:
//   A low m_ready holds the output register; replay and then parsing back up behind it.
`default_nettype none

module serial_frame_receiver_with_ack #(
    parameter int unsigned FRAME_BUFFER_BYTES = 64
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire sfr_pkg::in_item_t                 s_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output sfr_pkg::out_item_t                     m_data,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [sfr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [7:0]                        cfg_wdata
);

    localparam int unsigned MAX_PAYLOAD = FRAME_BUFFER_BYTES - sfr_pkg::FRAME_OVERHEAD;

    sfr_pkg::cfg_t        cfg_reg, cfg_next;
    sfr_pkg::frame_desc_t q_desc;
    sfr_pkg::frame_desc_t q_head;
    sfr_pkg::store_wr_t   store_wr;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_head_valid;

    // Configuration registers: take every write beat, ignore indexes past the list.
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                sfr_pkg::CFG_HEADER_FIRST:  cfg_next.header_first  = cfg_wdata;
                sfr_pkg::CFG_HEADER_SECOND: cfg_next.header_second = cfg_wdata;
                sfr_pkg::CFG_TAIL_FIRST:    cfg_next.tail_first    = cfg_wdata;
                sfr_pkg::CFG_TAIL_SECOND:   cfg_next.tail_second   = cfg_wdata;
                sfr_pkg::CFG_ACK_ENABLE:    cfg_next.ack_enable    = cfg_wdata[0];
                default:                    cfg_next               = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: parse bytes, fill the free bank, push a descriptor per deliverable frame.
    sfr_front #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_desc   (q_desc),
        .store_wr (store_wr)
    );

    // Queue: one entry per store bank.
    sfr_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_desc  (q_desc),
        .pop        (q_pop),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head       (q_head)
    );

    // Back: replay the head frame from its bank, with a fetch and an emit state per beat.
    sfr_back #(
        .FRAME_BUFFER_BYTES(FRAME_BUFFER_BYTES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .store_wr   (store_wr),
        .head_valid (q_head_valid),
        .head       (q_head),
        .pop        (q_pop),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

    // A frame completes only when a bank is free to hand over.
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("descriptor pushed into a full queue");

    // Replay finishes a frame only while it is at the queue head.
    a_pop_has_head: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_head_valid)
        else $error("frame retired from an empty queue");

    // The closing beat of a run sits at the end of the payload.
    a_last_index: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.last && (MAX_PAYLOAD < 64)) |->
            ((m_data.payload_length == 6'd0 && m_data.byte_index == 6'd0) ||
             (m_data.byte_index + 6'd1 == m_data.payload_length)))
        else $error("last beat does not close the payload run");

    // The first edge out of reset sees an empty output register.
    a_reset_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result beat shown right after reset");

endmodule

`default_nettype wire
